[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CC20_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cc20 assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define CC20_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cc20 assertion failed");

`endif

[rtl/cc20_pkg.sv]
package cc20_pkg;

  localparam int Rounds = 20;
  localparam int RndW   = (Rounds > 1) ? $clog2(Rounds) : 1;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;
  typedef word_t [3:0]  quad_t;

  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646e;
  localparam word_t Sigma2 = 32'h7962_2d32;
  localparam word_t Sigma3 = 32'h6b20_6574;

  typedef enum logic [2:0] {
    RegKey01     = 3'd0,
    RegKey23     = 3'd1,
    RegKey45     = 3'd2,
    RegKey67     = 3'd3,
    RegNonceLow  = 3'd4,
    RegNonceTop  = 3'd5,
    RegInitCount = 3'd6
  } cc20_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch the input beat
    logic load;     // load working state from the input block
    logic restart;  // on load: take the counter from initial_counter
    logic round;    // run one round
    logic odd;      // diagonal round when set
    logic finish;   // feed-forward add, advance counter
    logic emit;     // write the output register
  } cc20_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_restart;  // restart flag of the beat on the input port
    logic last;        // latched end_of_message
    logic pos_end;     // current keystream word is the last of the block
  } cc20_status_t;

  function automatic quad_t quarter(quad_t v);
    word_t a, b, c, d, t;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; t = d ^ a; d = {t[15:0], t[31:16]};
    c = c + d; t = b ^ c; b = {t[19:0], t[31:20]};
    a = a + b; t = d ^ a; d = {t[23:0], t[31:24]};
    c = c + d; t = b ^ c; b = {t[24:0], t[31:25]};
    return {d, c, b, a};
  endfunction

  // One column round (odd = 0) or diagonal round (odd = 1).
  function automatic blk_t round_fn(blk_t x, logic odd);
    blk_t  y;
    quad_t q;
    int    ib, ic, id;
    y = x;
    for (int i = 0; i < 4; i++) begin
      ib = odd ? 4 + ((i + 1) & 3) : 4 + i;
      ic = odd ? 8 + ((i + 2) & 3) : 8 + i;
      id = odd ? 12 + ((i + 3) & 3) : 12 + i;
      q = quarter({x[id], x[ic], x[ib], x[i]});
      y[i]  = q[0];
      y[ib] = q[1];
      y[ic] = q[2];
      y[id] = q[3];
    end
    return y;
  endfunction

  function automatic word_t byte_mask(logic [2:0] n);
    word_t m;
    unique case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

[rtl/cc20_if.sv]
interface cc20_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;
  logic        restart;

  modport source(output valid, message_word, valid_bytes, end_of_message, restart,
                 input ready);
  modport sink(input valid, message_word, valid_bytes, end_of_message, restart,
               output ready);
endinterface

interface cc20_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic [2:0]  out_valid_bytes;
  logic        out_last;

  modport source(output valid, cipher_word, out_valid_bytes, out_last, input ready);
  modport sink(input valid, cipher_word, out_valid_bytes, out_last, output ready);
endinterface

interface cc20_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/cc20_datapath.sv]
module cc20_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cc20_pkg::cc20_cmd_t   cmd_i,
  output cc20_pkg::cc20_status_t status_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i,
  input  logic [31:0]           message_word_i,
  input  logic [2:0]            valid_bytes_i,
  input  logic                  end_of_message_i,
  input  logic                  restart_i,
  output logic [31:0]           cipher_word_o,
  output logic [2:0]            out_valid_bytes_o,
  output logic                  out_last_o
);

  logic [63:0]         key_q [4];
  logic [63:0]         nonce_low_q;
  logic [31:0]         nonce_top_q;
  logic [31:0]         init_count_q;
  logic [31:0]         count_q, count_d;
  logic [3:0]          pos_q, pos_d;

  cc20_pkg::blk_t      x_q;       // working state, then keystream block
  cc20_pkg::blk_t      in_blk;
  logic [31:0]         msg_q;
  logic [2:0]          vbytes_q;
  logic                last_q;
  logic [31:0]         cipher_q;
  logic [2:0]          ovb_q;
  logic                olast_q;

  // counter used for the block input: chosen at load, held during rounds
  assign count_d = (cmd_i.load && cmd_i.restart) ? init_count_q : count_q;

  always_comb begin
    in_blk[0]  = cc20_pkg::Sigma0;
    in_blk[1]  = cc20_pkg::Sigma1;
    in_blk[2]  = cc20_pkg::Sigma2;
    in_blk[3]  = cc20_pkg::Sigma3;
    for (int i = 0; i < 4; i++) begin
      in_blk[4 + 2 * i] = key_q[i][31:0];
      in_blk[5 + 2 * i] = key_q[i][63:32];
    end
    in_blk[12] = count_d;
    in_blk[13] = nonce_low_q[31:0];
    in_blk[14] = nonce_low_q[63:32];
    in_blk[15] = nonce_top_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.load || cmd_i.finish) begin
      pos_d = '0;
    end else if (cmd_i.emit) begin
      pos_d = last_q ? 4'd0 : pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      nonce_low_q  <= '0;
      nonce_top_q  <= '0;
      init_count_q <= '0;
      count_q      <= '0;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cc20_pkg::RegKey01:     key_q[0]     <= cfg_data_i;
          cc20_pkg::RegKey23:     key_q[1]     <= cfg_data_i;
          cc20_pkg::RegKey45:     key_q[2]     <= cfg_data_i;
          cc20_pkg::RegKey67:     key_q[3]     <= cfg_data_i;
          cc20_pkg::RegNonceLow:  nonce_low_q  <= cfg_data_i;
          cc20_pkg::RegNonceTop:  nonce_top_q  <= cfg_data_i[31:0];
          cc20_pkg::RegInitCount: init_count_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        count_q <= count_d;
      end else if (cmd_i.finish) begin
        count_q <= count_q + 32'd1;
      end
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      msg_q    <= message_word_i;
      vbytes_q <= valid_bytes_i;
      last_q   <= end_of_message_i;
    end
    if (cmd_i.load) begin
      x_q <= in_blk;
    end else if (cmd_i.round) begin
      x_q <= cc20_pkg::round_fn(x_q, cmd_i.odd);
    end else if (cmd_i.finish) begin
      for (int i = 0; i < 16; i++) begin
        x_q[i] <= x_q[i] + in_blk[i];
      end
    end
    if (cmd_i.emit) begin
      cipher_q <= (msg_q ^ x_q[pos_q]) & cc20_pkg::byte_mask(vbytes_q);
      ovb_q    <= vbytes_q;
      olast_q  <= last_q;
    end
  end

  assign status_o.in_restart = restart_i;
  assign status_o.last       = last_q;
  assign status_o.pos_end    = (pos_q == 4'd15);

  assign cipher_word_o     = cipher_q;
  assign out_valid_bytes_o = ovb_q;
  assign out_last_o        = olast_q;

endmodule

[rtl/cc20_ctrl.sv]
`include "assert_macros.svh"

module cc20_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cc20_pkg::cc20_status_t status_i,
  output cc20_pkg::cc20_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_e;

  state_e                    state_q;
  logic [cc20_pkg::RndW-1:0] rnd_q;
  logic                      blk_ready_q;
  logic                      out_valid_q;
  logic                      accept;
  logic                      need_blk;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign need_blk    = status_i.in_restart || !blk_ready_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.load    = accept && need_blk;
    cmd_o.restart = status_i.in_restart;
    cmd_o.odd     = rnd_q[0];
    unique case (state_q)
      S_IDLE:  ;
      S_ROUND: cmd_o.round  = 1'b1;
      S_ADD:   cmd_o.finish = 1'b1;
      S_EMIT:  cmd_o.emit   = !out_valid_q || out_ready_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      blk_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            rnd_q   <= '0;
            state_q <= need_blk ? S_ROUND : S_EMIT;
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + cc20_pkg::RndW'(1);
          if (rnd_q == cc20_pkg::RndW'(cc20_pkg::Rounds - 1)) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          blk_ready_q <= 1'b1;
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd_o.emit) begin
            // block used up or message over: next beat starts a new block
            if (status_i.pos_end || status_i.last) begin
              blk_ready_q <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  `CC20_ASSERT(a_emit_slot_free, clk_i, rst_ni, !cmd_o.emit || !out_valid_q || out_ready_i)
  `CC20_ASSERT(a_round_in_range, clk_i, rst_ni,
               state_q != S_ROUND || rnd_q <= cc20_pkg::RndW'(cc20_pkg::Rounds - 1))
  `CC20_ASSERT_NEXT(a_held_block_emits, clk_i, rst_ni,
                    accept && blk_ready_q && !status_i.in_restart, state_q == S_EMIT)
  `CC20_ASSERT_NEXT(a_add_then_emit, clk_i, rst_ni,
                    state_q == S_ADD, state_q == S_EMIT && blk_ready_q)

endmodule

[rtl/chacha20_stream_cipher.sv]
// Flow: a beat is accepted only in the idle state. With a keystream block held it goes
// to the emit state; otherwise it passes the round, add and emit states, the rounds run
// on the single round unit iterated once per round. The result is registered on emit,
// which stalls while the output holds an unaccepted word; no new beat is taken until then.
// Reset: asynchronous, active low; clears configuration, counter, word position and
// the held-block flag. Keystream storage is not reset.
module chacha20_stream_cipher (
  input  logic           clk_i,
  input  logic           rst_ni,
  cc20_cfg_if.sink       cfg_i,
  cc20_in_if.sink        msg_i,
  cc20_out_if.source     res_o
);

  cc20_pkg::cc20_cmd_t    cmd;
  cc20_pkg::cc20_status_t status;

  assign cfg_i.ready = 1'b1;

  cc20_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_ready_o  (msg_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cc20_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .message_word_i    (msg_i.message_word),
    .valid_bytes_i     (msg_i.valid_bytes),
    .end_of_message_i  (msg_i.end_of_message),
    .restart_i         (msg_i.restart),
    .cipher_word_o     (res_o.cipher_word),
    .out_valid_bytes_o (res_o.out_valid_bytes),
    .out_last_o        (res_o.out_last)
  );

endmodule
